// ===== rtl/core/totp_pkg.sv =====
// Shared constants, types and helpers for the TOTP HMAC-SHA1 generator.
// No dependencies; every other file in rtl/core depends on this package.
package totp_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned PwdW    = 20;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned KeyWords = 4;

  // divide by 30: 16 quotient bits per cycle, q = (v * RECIP_30) >> 26 is exact
  // for v < 30 * 2^16
  localparam logic [4:0]  STEP_SECONDS  = 5'd30;
  localparam int unsigned DivDigitW     = 16;
  localparam int unsigned DivSteps      = 4;
  localparam logic [21:0] RECIP_30      = 22'd2236963;
  localparam int unsigned RecipDivShift = 26;

  // mod 1e6: q = (v * RECIP_1E6) >> 50 is exact for any 31-bit v, q fits 12 bits
  localparam logic [30:0] OTP_MOD       = 31'd1000000;
  localparam int unsigned ModSteps      = 1;   // reciprocal-multiply quotient steps
  localparam int unsigned ModQW         = 12;
  localparam logic [30:0] RECIP_1E6     = 31'd1125899907;
  localparam int unsigned RecipModShift = 50;

  localparam logic [7:0]  IPAD = 8'h36;
  localparam logic [7:0]  OPAD = 8'h5C;
  localparam logic [63:0] INNER_BITS = 64'd576;  // 72 bytes
  localparam logic [63:0] OUTER_BITS = 64'd672;  // 84 bytes

  localparam logic [31:0] H0_0 = 32'h67452301;
  localparam logic [31:0] H0_1 = 32'hEFCDAB89;
  localparam logic [31:0] H0_2 = 32'h98BADCFE;
  localparam logic [31:0] H0_3 = 32'h10325476;
  localparam logic [31:0] H0_4 = 32'hC3D2E1F0;

  // Block order of one HMAC: inner key, inner message, outer key, outer message.
  localparam logic [1:0] BLK_IKEY = 2'd0;
  localparam logic [1:0] BLK_IMSG = 2'd1;
  localparam logic [1:0] BLK_OKEY = 2'd2;
  localparam logic [1:0] BLK_OMSG = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 8'd3;

  typedef struct packed {
    logic       div_load;
    logic       div_step;
    logic       blk_load;
    logic       h_init;
    logic       round;
    logic       h_add;
    logic       win_load;
    logic       mod_step;
    logic       out_load;
    logic [1:0] blk;
    logic [6:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

// ===== rtl/core/totp_if.sv =====
// Valid/ready channel interfaces for the TOTP generator: time in,
// password out, key register writes. Depends on totp_pkg.
interface totp_in_if;
  logic                            valid;
  logic                            ready;
  logic [totp_pkg::TimeW-1:0]      unix_seconds;
  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface totp_out_if;
  logic                            valid;
  logic                            ready;
  logic [totp_pkg::PwdW-1:0]       password;
  modport source (output valid, output password, input ready);
  modport sink   (input valid, input password, output ready);
endinterface

interface totp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [totp_pkg::CfgIdxW-1:0]    index;
  logic [totp_pkg::KeyW-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/totp_ctrl.sv =====
// Sequencer for the TOTP generator: steps divide, four SHA-1 blocks,
// modulo and output load. Depends on totp_pkg.
module totp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  totp_pkg::stat_t st,
  output totp_pkg::cmd_t  cmd
);
  import totp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_ADD   = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [1:0] blk_r, blk_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    blk_nxt   = blk_r;
    cmd       = '0;
    cmd.blk   = blk_r;
    cmd.rnd   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'(DivSteps - 1)) begin
          blk_nxt   = BLK_IKEY;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.blk_load = 1'b1;
        cmd.h_init   = (blk_r == BLK_IKEY) || (blk_r == BLK_OKEY);
        cnt_nxt      = '0;
        state_nxt    = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd79) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.h_add = 1'b1;
        cnt_nxt   = '0;
        if (blk_r == BLK_OMSG) begin
          state_nxt = S_MOD;
        end else begin
          blk_nxt   = blk_r + 2'd1;
          state_nxt = S_LOAD;
        end
      end
      S_MOD: begin
        // first cycle picks the window, then the reciprocal-multiply quotient
        if (cnt_r == 7'd0) cmd.win_load = 1'b1;
        else               cmd.mod_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(ModSteps)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      blk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      blk_r   <= blk_nxt;
    end
  end

endmodule

// ===== rtl/core/totp_dp.sv =====
// Datapath of the TOTP generator: key registers, divide-by-30, SHA-1 round
// engine, truncation, modulo and output register. Depends on totp_pkg, totp_if.
module totp_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [totp_pkg::TimeW-1:0] in_time,
  totp_cfg_if.sink        cfg,
  totp_out_if.source      res,
  input  totp_pkg::cmd_t  cmd,
  output totp_pkg::stat_t st
);
  import totp_pkg::*;

  logic [KeyW-1:0] key_r [KeyWords];

  // divide by 30, 16 quotient bits per cycle by reciprocal multiply
  logic [63:0] q_r;
  logic [4:0]  rem_r;
  logic [20:0] div_v, div_qm, div_rem;
  logic [42:0] div_prod;
  logic [DivDigitW-1:0] div_q;

  // SHA-1
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r [5];
  logic [159:0] ihash_r;
  logic [31:0] f, t, w_new;
  logic [31:0] hs [5];
  logic [511:0] blk_data;
  logic [255:0] key_all;

  // truncation and modulo
  logic [159:0] digest, digest_sh;
  logic [30:0]  mv_r, mod_qm, mod_rem;
  logic [61:0]  mod_prod;
  logic [ModQW-1:0] q_mod_r;

  logic [PwdW-1:0] pwd_r;
  logic            ov_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KeyWords; i++) key_r[i] <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY0: key_r[0] <= cfg.data;
        REG_KEY1: key_r[1] <= cfg.data;
        REG_KEY2: key_r[2] <= cfg.data;
        REG_KEY3: key_r[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // remainder and next 16 dividend bits, top digit first
  assign div_v    = {rem_r, q_r[TimeW-1 -: DivDigitW]};
  assign div_prod = 43'(div_v) * 43'(RECIP_30);
  assign div_q    = div_prod[RecipDivShift +: DivDigitW];
  assign div_qm   = 21'(div_q) * 21'(STEP_SECONDS);
  assign div_rem  = div_v - div_qm;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r   <= in_time;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_rem[4:0];
      q_r   <= {q_r[TimeW-DivDigitW-1:0], div_q};
    end
  end

  assign key_all = {key_r[0], key_r[1], key_r[2], key_r[3]};

  always_comb begin
    case (cmd.blk)
      BLK_IKEY: blk_data = {key_all, 256'b0} ^ {64{IPAD}};
      BLK_IMSG: blk_data = {q_r, 8'h80, 376'b0, INNER_BITS};
      BLK_OKEY: blk_data = {key_all, 256'b0} ^ {64{OPAD}};
      BLK_OMSG: blk_data = {ihash_r, 8'h80, 280'b0, OUTER_BITS};
      default:  blk_data = '0;
    endcase
  end

  always_comb begin
    if (cmd.rnd < 7'd20)      f = (b_r & c_r) | (~b_r & d_r);
    else if (cmd.rnd < 7'd40) f = b_r ^ c_r ^ d_r;
    else if (cmd.rnd < 7'd60) f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    else                      f = b_r ^ c_r ^ d_r;
  end

  assign t     = {a_r[26:0], a_r[31:27]} + f + e_r + sha1_k(cmd.rnd) + w_r[0];
  assign w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];

  assign hs[0] = h_r[0] + a_r;
  assign hs[1] = h_r[1] + b_r;
  assign hs[2] = h_r[2] + c_r;
  assign hs[3] = h_r[3] + d_r;
  assign hs[4] = h_r[4] + e_r;

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk_data[511 - 32*i -: 32];
      if (cmd.h_init) begin
        h_r[0] <= H0_0; h_r[1] <= H0_1; h_r[2] <= H0_2; h_r[3] <= H0_3; h_r[4] <= H0_4;
        a_r <= H0_0; b_r <= H0_1; c_r <= H0_2; d_r <= H0_3; e_r <= H0_4;
      end else begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= {w_new[30:0], w_new[31]};
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end else if (cmd.h_add) begin
      for (int i = 0; i < 5; i++) h_r[i] <= hs[i];
      if (cmd.blk == BLK_IMSG) ihash_r <= {hs[0], hs[1], hs[2], hs[3], hs[4]};
    end
  end

  // dynamic truncation: low nibble of the last byte picks the window
  assign digest    = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign digest_sh = digest << {h_r[4][3:0], 3'b000};

  // window mod 1e6: quotient by reciprocal multiply, remainder at output load
  assign mod_prod = 62'(mv_r) * 62'(RECIP_1E6);
  assign mod_qm   = 31'(q_mod_r) * OTP_MOD;
  assign mod_rem  = mv_r - mod_qm;

  always_ff @(posedge clk) begin
    if (cmd.win_load) begin
      mv_r <= digest_sh[158:128];
    end else if (cmd.mod_step) begin
      q_mod_r <= mod_prod[RecipModShift +: ModQW];
    end
  end

  assign st.out_free = !ov_r || res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (res.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) pwd_r <= mod_rem[PwdW-1:0];
  end

  assign res.valid    = ov_r;
  assign res.password = pwd_r;

endmodule

// ===== rtl/core/totp_hmac_sha1_generator.sv =====
// TOTP generator: unix time in, six-digit HMAC-SHA1 password out (0..999999).
// An accepted time is divided by 30 (16 quotient bits per cycle by reciprocal
// multiply), the step runs through four SHA-1 blocks (inner key, inner message,
// outer key, outer message) on one round engine at one round per cycle, then the
// truncation window is reduced modulo 1000000 (window pick, reciprocal-multiply
// quotient; remainder at output load). One item at a time: the next time is
// taken only once the result is loaded, and the pace is set by the 320 SHA-1
// rounds on the single round engine. A finished result sits in an output
// register so the input side can reopen while it waits; a result still held
// there stalls the next load. Key words are written through cfg_ch (index
// 0..3, others ignored), always ready; write them only while no time is in flight.
module totp_hmac_sha1_generator (
  input  logic        clk,
  input  logic        rst_n,
  totp_in_if.sink     in_ch,
  totp_out_if.source  out_ch,
  totp_cfg_if.sink    cfg_ch
);
  import totp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  totp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  totp_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_time (in_ch.unix_seconds),
    .cfg     (cfg_ch),
    .res     (out_ch),
    .cmd     (cmd),
    .st      (st)
  );

  // a transfer in closes the input until the result is loaded
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input reopened right after a transfer");

  a_pwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.password < 20'd1000000)
    else $error("password out of range");

  // a new result is only loaded at the end of a computation
  a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared while idle");

endmodule

// ===== tb/sv/tb_totp_hmac_sha1_generator.sv =====
// Self-checking testbench for totp_hmac_sha1_generator: times go in, six-digit passwords
// are checked against an HMAC-SHA1 TOTP predictor built into this file.
// Depends on totp_pkg, the channel interfaces in totp_if.sv and the generator RTL.
`timescale 1ns / 1ps

module tb_totp_hmac_sha1_generator;
  import totp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;  // covers one item plus the worst stalls
  localparam int unsigned TAIL_CYCLES    = 450;   // one full item latency and then some
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam logic [CfgIdxW-1:0] REG_BAD_LO = 8'd4;   // first index past the key words
  localparam logic [CfgIdxW-1:0] REG_BAD_HI = 8'hFF;
  localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};

  typedef enum logic [1:0] {ACT_TIME, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t         kind;
    logic [63:0]       value;  // time for ACT_TIME, key data for ACT_CFG
    logic [CfgIdxW-1:0] idx;
    bit                calm;   // no idling on either side once this is popped
  } action_t;

  logic clk;
  logic rst_n;

  totp_in_if  in_ch ();
  totp_out_if out_ch ();
  totp_cfg_if cfg_ch ();

  totp_hmac_sha1_generator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor: SHA-1 block compression and the TOTP truncation on top of it.
  // ---------------------------------------------------------------------------
  function automatic logic [159:0] sha1_compress(input logic [159:0] hin,
                                                 input logic [511:0] blk);
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    {a, b, c, d, e} = hin;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c, hin[63:32] + d,
            hin[31:0] + e};
  endfunction

  // 32-byte key is zero-padded to one block; the message blocks carry the
  // 0x80 terminator and the bit length (72 bytes inner, 84 bytes outer).
  function automatic logic [PwdW-1:0] password_for(input logic [TimeW-1:0] secs,
                                                   input logic [255:0] key);
    logic [511:0] kblk;
    logic [63:0]  counter;
    logic [159:0] ihash, mac;
    logic [31:0]  win;
    logic [3:0]   off;
    kblk    = {key, 256'b0};
    counter = secs / 64'd30;
    ihash = sha1_compress(sha1_compress(SHA1_IV, kblk ^ {64{IPAD}}),
                          {counter, 8'h80, 376'b0, 64'd576});
    mac   = sha1_compress(sha1_compress(SHA1_IV, kblk ^ {64{OPAD}}),
                          {ihash, 8'h80, 280'b0, 64'd672});
    off = mac[3:0];
    win = mac[159 - 8*int'(off) -: 32];
    win[31] = 1'b0;
    return PwdW'(win % 32'd1000000);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  action_t          work_q [$];
  logic [PwdW-1:0]  pwd_expected [$];
  logic [KeyW-1:0]  key_shadow [KeyWords];
  int unsigned      in_sent, in_taken, cfg_sent, cfg_taken;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  bit               calm_tail;

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge; inputs only move on
  // the falling edge, so no race with the DUT.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      bit moved;
      logic [PwdW-1:0] want;
      moved = 1'b0;
      // key writes first; the block is idle whenever one lands
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        cfg_taken++;
        case (cfg_ch.index)
          REG_KEY0: key_shadow[0] = cfg_ch.data;
          REG_KEY1: key_shadow[1] = cfg_ch.data;
          REG_KEY2: key_shadow[2] = cfg_ch.data;
          REG_KEY3: key_shadow[3] = cfg_ch.data;
          default: ;  // out of range, ignored by the block
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        in_taken++;
        pwd_expected.push_back(password_for(in_ch.unix_seconds,
            {key_shadow[0], key_shadow[1], key_shadow[2], key_shadow[3]}));
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pwd_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected password transfer, expected none, actual %0d",
                   $time, out_ch.password);
        end else begin
          want = pwd_expected.pop_front();
          if (out_ch.password !== want) begin
            mismatches++;
            $display("%0t: password mismatch, expected %0d, actual %0d",
                     $time, want, out_ch.password);
          end
        end
      end
      // watchdog: too long with no transfer on any channel
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d passwords still outstanding",
                 $time, pwd_expected.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: works through work_q at the falling edge. A time or key write is
  // held until its transfer is seen; a drain entry holds the sender until
  // every outstanding password is back.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      send_gap     = 0;
    end else if (in_ch.valid && in_taken != in_sent) begin
      // time still waiting for its transfer
    end else if (cfg_ch.valid && cfg_taken != cfg_sent) begin
      // key write still waiting for its transfer
    end else begin
      logic nxt_in, nxt_cfg;
      nxt_in  = 1'b0;
      nxt_cfg = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (work_q.size() != 0) begin
        case (work_q[0].kind)
          ACT_TIME: begin
            in_ch.unix_seconds <= work_q[0].value;
            nxt_in = 1'b1;
            in_sent++;
            calm_tail = work_q[0].calm;
            void'(work_q.pop_front());
            // occasional idle burst after this transfer
            if (!calm_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
          end
          ACT_CFG: begin
            cfg_ch.index <= work_q[0].idx;
            cfg_ch.data  <= work_q[0].value;
            nxt_cfg = 1'b1;
            cfg_sent++;
            void'(work_q.pop_front());
          end
          ACT_DRAIN: begin
            if (pwd_expected.size() == 0 && in_taken == in_sent && !out_ch.valid)
              void'(work_q.pop_front());
          end
          default: ;
        endcase
      end
      in_ch.valid  <= nxt_in;
      cfg_ch.valid <= nxt_cfg;
    end
  end

  // Receiver back-pressure in random bursts, none in the calm tail.
  int unsigned stall_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  task automatic add_time(input logic [63:0] secs, input bit calm = 1'b0);
    action_t a;
    a.kind = ACT_TIME; a.value = secs; a.idx = '0; a.calm = calm;
    work_q.push_back(a);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    action_t a;
    a.kind = ACT_CFG; a.value = data; a.idx = idx; a.calm = 1'b0;
    work_q.push_back(a);
  endtask

  // waits for an empty pipeline: used before every key change
  task automatic add_drain();
    action_t a;
    a.kind = ACT_DRAIN; a.value = '0; a.idx = '0; a.calm = 1'b0;
    work_q.push_back(a);
  endtask

  task automatic add_key(input logic [63:0] k0, k1, k2, k3);
    add_drain();
    add_write(REG_KEY0, k0);
    add_write(REG_KEY1, k1);
    add_write(REG_KEY2, k2);
    add_write(REG_KEY3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mix of plausible clock values, 30-second boundaries, tiny, huge and raw.
  function automatic logic [63:0] pick_time();
    logic [63:0] base;
    case ($urandom_range(0, 5))
      0: return 64'd1_500_000_000 + $urandom_range(0, 900_000_000);
      1: begin
        base = (rand64() >> $urandom_range(0, 40)) / 30 * 30;
        return base + $urandom_range(0, 2) - 64'd1;
      end
      2: return 64'($urandom_range(0, 1000));
      3: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100);
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] directed [$];
    in_ch.valid = 1'b0;
    in_ch.unix_seconds = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    in_sent = 0; in_taken = 0; cfg_sent = 0; cfg_taken = 0;
    mismatches = 0; quiet_cycles = 0; calm_tail = 1'b0;
    foreach (key_shadow[i]) key_shadow[i] = '0;

    // Directed: step boundaries, extremes and the classic test-vector times.
    directed = '{64'd0, 64'd1, 64'd29, 64'd30, 64'd31, 64'd59, 64'd59, 64'd1111111109,
                 64'd1234567890, 64'd2000000000, 64'd20000000000,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
    // reset key (all zero) first
    foreach (directed[i]) if (i < 10) add_time(directed[i]);
    // all-ones key; writes to unused indexes must change nothing
    add_key('1, '1, '1, '1);
    add_write(REG_BAD_LO, rand64());
    add_write(REG_BAD_HI, rand64());
    foreach (directed[i]) if (i >= 8) add_time(directed[i]);

    // Random phases, each under its own key; last phase ends without idling.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) add_key('0, '0, '0, '0);
      else add_key(rand64(), rand64(), rand64(), rand64());
      if ($urandom_range(0, 1))
        add_write(CfgIdxW'(REG_BAD_LO + $urandom_range(0, 200)), rand64());
      for (int n = 0; n < PHASE_ITEMS; n++)
        add_time(pick_time(), ph == RAND_PHASES - 1 && n >= PHASE_ITEMS / 2);
    end

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (work_q.size() != 0 || pwd_expected.size() != 0 || in_taken != in_sent)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
